// ----- hw/rtl/lsc_pkg.sv -----
// ----------------------------------------------------------------------------
// Latency search controller package
// Shared constants, codes, state encoding and control structs.
// ----------------------------------------------------------------------------
package lsc_pkg;

	// Default latency width.
	localparam int LSC_LAT_BITS = 10;

	// Configuration port geometry.
	localparam int LSC_ADDR_BITS = 5;
	localparam int LSC_DATA_BITS = 32;
	localparam int LSC_IDX_BITS  = 3;

	// Slave stream payload width (attempt_success, padded to a byte).
	localparam int LSC_IN_BITS = 8;

	// Register indexes.
	localparam logic [LSC_IDX_BITS-1:0] REG_STRATEGY    = 3'd0;
	localparam logic [LSC_IDX_BITS-1:0] REG_LOWER_BOUND = 3'd1;
	localparam logic [LSC_IDX_BITS-1:0] REG_UPPER_BOUND = 3'd2;
	localparam logic [LSC_IDX_BITS-1:0] REG_JUMP_LENGTH = 3'd3;
	localparam logic [LSC_IDX_BITS-1:0] REG_SINGLE_TRY  = 3'd4;

	// Search strategy codes.
	localparam logic [2:0] STRAT_REV_LINEAR  = 3'd0;
	localparam logic [2:0] STRAT_LINEAR      = 3'd1;
	localparam logic [2:0] STRAT_LINEAR_JUMP = 3'd2;
	localparam logic [2:0] STRAT_JUMP_BINARY = 3'd3;
	localparam logic [2:0] STRAT_BINARY      = 3'd4;
	localparam logic [2:0] STRAT_NONE        = 3'd5;

	// Controller states, one-hot.
	typedef enum logic [7:0] {
		ST_CLEAR   = 8'b0000_0001,
		ST_IDLE    = 8'b0000_0010,
		ST_SQRT    = 8'b0000_0100,
		ST_DECIDE  = 8'b0000_1000,
		ST_LOOKUP  = 8'b0001_0000,
		ST_MARK    = 8'b0010_0000,
		ST_EMIT    = 8'b0100_0000,
		ST_RESTART = 8'b1000_0000
	} lsc_state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;
		logic sqrt_run;
		logic decide;
		logic lookup;
		logic mark;
		logic restart;
		logic clear;
		logic res_load;
	} lsc_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic restart_req;
		logic jump_neg;
		logic needs_mark;
		logic clear_done;
	} lsc_stat_t;

endpackage

// ----- hw/rtl/lsc_ctrl.sv -----
// ----------------------------------------------------------------------------
// Latency search controller sequencer
// One-hot state machine that steps the datapath through one request.
// ----------------------------------------------------------------------------
module lsc_ctrl
	import lsc_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  logic      out_free,
	input  lsc_stat_t stat,
	output lsc_cmd_t  cmd
);

	lsc_state_t state_q;
	lsc_state_t state_d;

	// Next state and command decode.
	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			ST_CLEAR: begin
				cmd.clear = 1'b1;
				if (stat.clear_done) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_SQRT;
				end
			end
			ST_SQRT: begin
				if (stat.restart_req) begin
					state_d = ST_RESTART;
				end else begin
					cmd.sqrt_run = 1'b1;
					if (!stat.jump_neg) begin
						state_d = ST_DECIDE;
					end
				end
			end
			ST_DECIDE: begin
				cmd.decide = 1'b1;
				state_d    = stat.needs_mark ? ST_LOOKUP : ST_EMIT;
			end
			ST_LOOKUP: begin
				cmd.lookup = 1'b1;
				state_d    = ST_MARK;
			end
			ST_MARK: begin
				cmd.mark = 1'b1;
				state_d  = ST_EMIT;
			end
			ST_EMIT: begin
				if (out_free) begin
					cmd.res_load = 1'b1;
					state_d      = stat.restart_req ? ST_CLEAR : ST_IDLE;
				end
			end
			ST_RESTART: begin
				cmd.restart = 1'b1;
				state_d     = ST_EMIT;
			end
			default: begin
				state_d = ST_CLEAR;
			end
		endcase
	end

	// State register; reset starts with a clearing pass.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	// A result is only handed over when the output register can take it.
	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.res_load |-> out_free)
		else $error("result loaded into a busy output register");

	// The map bit is checked only after a read was issued the cycle before.
	a_mark_order: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_MARK) |-> $past(state_q == ST_LOOKUP))
		else $error("map check without a preceding read");

	// A decision never uses an unresolved automatic jump length.
	a_jump_ready: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DECIDE) |-> !stat.jump_neg)
		else $error("decision taken with automatic jump still pending");

endmodule

// ----- hw/rtl/lsc_datapath.sv -----
// ----------------------------------------------------------------------------
// Latency search controller datapath
// Search state, jump length unit, next candidate logic and tried-latency map.
// ----------------------------------------------------------------------------
module lsc_datapath
	import lsc_pkg::*;
#(
	parameter int LATENCY_BITS = LSC_LAT_BITS
)(
	input  logic                    clk,
	input  logic                    arst_n,
	input  lsc_cmd_t                cmd,
	output lsc_stat_t               stat,
	input  logic                    in_restart,
	input  logic                    in_ok,
	input  logic [2:0]              cfg_strategy,
	input  logic [LATENCY_BITS-1:0] cfg_lower,
	input  logic [LATENCY_BITS-1:0] cfg_upper,
	input  logic [LATENCY_BITS:0]   cfg_jump,
	input  logic                    cfg_single,
	output logic [LATENCY_BITS:0]   res_cand,
	output logic                    res_go
);

	localparam int LB    = LATENCY_BITS;
	localparam int DEPTH = 1 << LB;

	// Search state.
	logic          cv_q;
	logic [LB-1:0] cand_q;
	logic [LB-1:0] lo_q;
	logic [LB-1:0] hi_q;
	logic          jmp_neg_q;
	logic [LB-1:0] jmp_q;
	logic          seen_q;
	logic          restart_q;
	logic          ok_q;
	logic          go_q;

	// Automatic jump unit: j and 4*j*j.
	logic [LB-1:0] j_q;
	logic [LB+1:0] s4_q;
	logic [LB-1:0] range;

	// Tried-latency map and its clearing counter.
	logic          tried_map_q [DEPTH];
	logic          rd_q;
	logic [LB-1:0] clr_cnt_q;
	logic          mem_we;
	logic [LB-1:0] mem_waddr;
	logic          mem_wdata;

	// Next-candidate logic.
	logic          nxt_cv;
	logic [LB-1:0] nxt_cand;
	logic [LB-1:0] nxt_lo;
	logic [LB-1:0] nxt_hi;
	logic          nxt_go;
	logic          nxt_mark;
	logic [LB:0]   sum_lo_j;
	logic [LB:0]   sum_c_j;
	logic [LB:0]   sum_c_lo;
	logic [LB:0]   sum_c_hi1;
	logic [LB-1:0] jump_from_lo;
	logic [LB-1:0] jump_from_c;
	logic          no_opt;

	assign range = (hi_q > lo_q) ? (hi_q - lo_q) : '0;

	assign sum_lo_j  = {1'b0, lo_q} + {1'b0, jmp_q};
	assign sum_c_j   = {1'b0, cand_q} + {1'b0, jmp_q};
	assign sum_c_lo  = {1'b0, cand_q} + {1'b0, lo_q};
	assign sum_c_hi1 = {1'b0, cand_q} + {1'b0, hi_q} + {{LB{1'b0}}, 1'b1};

	assign jump_from_lo = (sum_lo_j > {1'b0, hi_q}) ? hi_q : sum_lo_j[LB-1:0];
	assign jump_from_c  = (sum_c_j > {1'b0, hi_q}) ? hi_q : sum_c_j[LB-1:0];

	assign no_opt = cfg_single || (cfg_strategy == STRAT_NONE);

	// Next search state for one reported outcome.
	always_comb begin
		nxt_cv   = cv_q;
		nxt_cand = cand_q;
		nxt_lo   = lo_q;
		nxt_hi   = hi_q;
		nxt_go   = 1'b0;
		nxt_mark = 1'b0;
		if (no_opt) begin
			if (!cv_q) begin
				nxt_cv   = 1'b1;
				nxt_cand = hi_q;
				nxt_go   = 1'b1;
			end
		end else begin
			unique case (cfg_strategy)
				STRAT_REV_LINEAR: begin
					if (!cv_q) begin
						nxt_cv   = 1'b1;
						nxt_cand = hi_q;
						nxt_go   = 1'b1;
					end else if (ok_q && cand_q > lo_q) begin
						nxt_cand = cand_q - 1'b1;
						nxt_go   = 1'b1;
					end
				end
				STRAT_LINEAR: begin
					if (!cv_q) begin
						nxt_cv   = 1'b1;
						nxt_cand = lo_q;
						nxt_go   = 1'b1;
					end else if (!ok_q && cand_q < hi_q) begin
						nxt_cand = cand_q + 1'b1;
						nxt_go   = 1'b1;
					end
				end
				STRAT_LINEAR_JUMP: begin
					if (!cv_q) begin
						nxt_cv   = 1'b1;
						nxt_cand = jump_from_lo;
						nxt_go   = 1'b1;
					end else if (ok_q) begin
						if (cand_q > lo_q) begin
							nxt_hi   = cand_q;
							nxt_cand = cand_q - 1'b1;
							nxt_go   = 1'b1;
						end
					end else if (!seen_q && cand_q < hi_q) begin
						nxt_lo   = cand_q + 1'b1;
						nxt_cand = jump_from_c;
						nxt_go   = 1'b1;
					end
				end
				STRAT_JUMP_BINARY: begin
					if (!cv_q) begin
						nxt_cv   = 1'b1;
						nxt_cand = lo_q;
						nxt_go   = 1'b1;
					end else if (seen_q) begin
						nxt_mark = 1'b1;
						if (ok_q) begin
							nxt_hi   = cand_q;
							nxt_cand = sum_c_lo[LB:1];
						end else begin
							// A failure at the greatest latency keeps the bound there.
							nxt_lo   = (&cand_q) ? cand_q : cand_q + 1'b1;
							nxt_cand = sum_c_hi1[LB:1];
						end
					end else if (cand_q < hi_q) begin
						nxt_lo   = cand_q + 1'b1;
						nxt_cand = jump_from_c;
						nxt_go   = 1'b1;
					end
				end
				STRAT_BINARY: begin
					nxt_mark = 1'b1;
					if (!cv_q) begin
						nxt_cv   = 1'b1;
						nxt_cand = lo_q;
					end else if (ok_q) begin
						nxt_hi   = cand_q;
						nxt_cand = sum_c_lo[LB:1];
					end else begin
						nxt_lo   = cand_q;
						nxt_cand = sum_c_hi1[LB:1];
					end
				end
				default: begin
					nxt_go = 1'b0;
				end
			endcase
		end
	end

	// Search state registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cv_q      <= 1'b0;
			cand_q    <= '0;
			lo_q      <= '0;
			hi_q      <= '0;
			jmp_neg_q <= 1'b1;
			jmp_q     <= '1;
			seen_q    <= 1'b0;
			restart_q <= 1'b0;
			ok_q      <= 1'b0;
			go_q      <= 1'b0;
			j_q       <= '0;
			s4_q      <= '0;
			clr_cnt_q <= '0;
		end else begin
			if (cmd.load) begin
				restart_q <= in_restart;
				ok_q      <= in_ok;
				j_q       <= '0;
				s4_q      <= '0;
				if (!in_restart && in_ok && cv_q) begin
					seen_q <= 1'b1;
				end
			end
			// One jump candidate per cycle until 4*j*j reaches the range.
			if (cmd.sqrt_run && jmp_neg_q) begin
				if (s4_q < {2'b00, range}) begin
					j_q  <= j_q + 1'b1;
					s4_q <= s4_q + (LB+2)'({j_q, 3'b000}) + (LB+2)'(4);
				end else begin
					jmp_neg_q <= 1'b0;
					jmp_q     <= j_q;
				end
			end
			if (cmd.decide) begin
				cv_q   <= nxt_cv;
				cand_q <= nxt_cand;
				lo_q   <= nxt_lo;
				hi_q   <= nxt_hi;
				go_q   <= nxt_go;
			end
			if (cmd.mark) begin
				go_q <= !rd_q;
			end
			if (cmd.restart) begin
				cv_q      <= 1'b0;
				lo_q      <= cfg_lower;
				hi_q      <= cfg_upper;
				jmp_neg_q <= cfg_jump[LB];
				jmp_q     <= cfg_jump[LB-1:0];
				seen_q    <= 1'b0;
				go_q      <= 1'b0;
				clr_cnt_q <= '0;
			end
			if (cmd.clear) begin
				clr_cnt_q <= clr_cnt_q + 1'b1;
			end
		end
	end

	// Map write port: clearing pass or marking the current candidate.
	assign mem_we    = cmd.clear || cmd.mark;
	assign mem_waddr = cmd.clear ? clr_cnt_q : cand_q;
	assign mem_wdata = !cmd.clear;

	always_ff @(posedge clk) begin
		if (mem_we) begin
			tried_map_q[mem_waddr] <= mem_wdata;
		end
	end

	// Registered map read at the current candidate.
	always_ff @(posedge clk) begin
		if (cmd.lookup) begin
			rd_q <= tried_map_q[cand_q];
		end
	end

	// Status and result.
	assign stat.restart_req = restart_q;
	assign stat.jump_neg    = jmp_neg_q;
	assign stat.needs_mark  = nxt_mark;
	assign stat.clear_done  = &clr_cnt_q;

	assign res_cand = cv_q ? {1'b0, cand_q} : '1;
	assign res_go   = go_q;

	// The candidate is only dropped by a restart.
	a_cand_drop: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(cv_q) |-> $past(cmd.restart))
		else $error("candidate lost without a restart");

	// Marking always concerns an existing candidate.
	a_mark_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.mark |-> cv_q)
		else $error("map marked with no candidate");

endmodule

// ----- hw/rtl/latency_search_controller.sv -----
// ----------------------------------------------------------------------------
// Latency search controller
// Proposes the next candidate latency from the outcome of the last attempt.
//
//   Channel   Dir  Handshake          Payload
//   s_*       in   s_tvalid/s_tready  s_tuser: command; s_tdata[0]: success
//   m_*       out  m_tvalid/m_tready  m_tdata: candidate_latency, keep_going
//   apb       in   psel/penable       strategy, bounds, jump_length, single_try
//
// After acceptance a report passes the jump check, the decision and the
// hand-over to the output register. The bisect phases add a map read and a
// map update before the hand-over. The first report after reset or after a
// restart with automatic jump length also runs the square root search in the
// jump check until 4*j*j reaches upper-lower. A restart passes the jump check
// and the restart step to the hand-over, then the tried-latency map is cleared
// one entry per cycle with s_tready low; the same pass runs after reset. The
// hand-over waits while the output register holds an unaccepted result; a new
// request is taken while a result still waits in the output register.
// ----------------------------------------------------------------------------
module latency_search_controller
	import lsc_pkg::*;
#(
	parameter int  LATENCY_BITS = LSC_LAT_BITS,
	localparam int OUT_BITS     = ((LATENCY_BITS + 2 + 7) / 8) * 8
)(
	input  logic                     clk,
	input  logic                     arst_n,
	// Request stream.
	input  logic                     s_tvalid,
	output logic                     s_tready,
	input  logic [LSC_IN_BITS-1:0]   s_tdata,   // [0] attempt_success, rest zero
	input  logic                     s_tuser,   // [0] command
	// Result stream.
	output logic                     m_tvalid,
	input  logic                     m_tready,
	output logic [OUT_BITS-1:0]      m_tdata,   // candidate_latency, keep_going, zeros
	// Configuration port.
	input  logic                     psel,
	input  logic                     penable,
	input  logic                     pwrite,
	input  logic [LSC_ADDR_BITS-1:0] paddr,
	input  logic [LSC_DATA_BITS-1:0] pwdata,
	output logic [LSC_DATA_BITS-1:0] prdata,
	output logic                     pready
);

	localparam int LB = LATENCY_BITS;

	// Configuration registers.
	logic [2:0]              strategy_q;
	logic [LB-1:0]           lower_q;
	logic [LB-1:0]           upper_q;
	logic [LB:0]             jump_q;
	logic                    single_q;
	logic [LSC_IDX_BITS-1:0] reg_idx;
	logic                    wr_en;

	// Output register.
	logic                    m_tvalid_q;
	logic [OUT_BITS-1:0]     m_tdata_q;
	logic                    out_free;

	// Controller and datapath links.
	lsc_cmd_t                cmd;
	lsc_stat_t               stat;
	logic [LB:0]             res_cand;
	logic                    res_go;

	assign pready  = 1'b1;
	assign reg_idx = paddr[LSC_ADDR_BITS-1:2];
	assign wr_en   = psel && penable && pwrite && pready;

	// Register writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strategy_q <= STRAT_REV_LINEAR;
			lower_q    <= '0;
			upper_q    <= '0;
			jump_q     <= '1;
			single_q   <= 1'b0;
		end else if (wr_en) begin
			unique case (reg_idx)
				REG_STRATEGY:    strategy_q <= pwdata[2:0];
				REG_LOWER_BOUND: lower_q    <= pwdata[LB-1:0];
				REG_UPPER_BOUND: upper_q    <= pwdata[LB-1:0];
				REG_JUMP_LENGTH: jump_q     <= pwdata[LB] ? '1 : {1'b0, pwdata[LB-1:0]};
				REG_SINGLE_TRY:  single_q   <= pwdata[0];
				default:         single_q   <= single_q;
			endcase
		end
	end

	// Register reads.
	always_comb begin
		unique case (reg_idx)
			REG_STRATEGY:    prdata = {{(LSC_DATA_BITS-3){1'b0}}, strategy_q};
			REG_LOWER_BOUND: prdata = {{(LSC_DATA_BITS-LB){1'b0}}, lower_q};
			REG_UPPER_BOUND: prdata = {{(LSC_DATA_BITS-LB){1'b0}}, upper_q};
			REG_JUMP_LENGTH: prdata = {{(LSC_DATA_BITS-LB-1){jump_q[LB]}}, jump_q};
			REG_SINGLE_TRY:  prdata = {{(LSC_DATA_BITS-1){1'b0}}, single_q};
			default:         prdata = '0;
		endcase
	end

	// Output register between the datapath and the result stream.
	assign out_free = !m_tvalid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (cmd.res_load) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.res_load) begin
			m_tdata_q <= {{(OUT_BITS-LB-2){1'b0}}, res_go, res_cand};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	lsc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.out_free (out_free),
		.stat     (stat),
		.cmd      (cmd)
	);

	lsc_datapath #(
		.LATENCY_BITS (LB)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.stat         (stat),
		.in_restart   (s_tuser),
		.in_ok        (s_tdata[0]),
		.cfg_strategy (strategy_q),
		.cfg_lower    (lower_q),
		.cfg_upper    (upper_q),
		.cfg_jump     (jump_q),
		.cfg_single   (single_q),
		.res_cand     (res_cand),
		.res_go       (res_go)
	);

endmodule

// ----- dv/tb_latency_search_controller.sv -----
// ----------------------------------------------------------------------------
// Latency search controller testbench
// Drives outcome reports and restart requests into the controller, programs
// the search registers over APB between phases, and checks every candidate
// and continue flag against a cycle-free model of the search state.
// ----------------------------------------------------------------------------
module tb_latency_search_controller;
	import lsc_pkg::*;

	localparam int LAT_MAX    = (1 << LSC_LAT_BITS) - 1;
	localparam int RES_BITS   = ((LSC_LAT_BITS + 2 + 7) / 8) * 8;
	localparam int CYCLE_CAP  = 6000000;
	localparam int SEARCH_CAP = 50;
	localparam int PHASE_ITEMS = 62;
	localparam int NUM_PHASES  = 16;

	// Strategy codes the package leaves unnamed; the block must hold still on them.
	localparam logic [2:0] STRAT_RSVD_6 = 3'd6;
	localparam logic [2:0] STRAT_RSVD_7 = 3'd7;

	// Command values carried on s_tuser.
	localparam bit CMD_REPORT  = 1'b0;
	localparam bit CMD_RESTART = 1'b1;

	typedef struct packed {
		logic [LSC_LAT_BITS:0] cand;
		logic                  go;
	} lat_result_t;

	// Search state tracker and result checker.
	class latency_scoreboard;
		logic [2:0] strategy;
		int         lower_reg, upper_reg, jump_reg;
		bit         single_try;
		int         cand, w_lower, w_upper, w_jump;
		bit         seen, last_go;
		bit         tried [0:LAT_MAX];
		lat_result_t expected_q[$];
		int         errors;

		function void power_on();
			strategy   = STRAT_REV_LINEAR;
			lower_reg  = 0;
			upper_reg  = 0;
			jump_reg   = -1;
			single_try = 0;
			errors     = 0;
			last_go    = 0;
			restart_search();
		endfunction

		function void restart_search();
			cand    = -1;
			w_lower = lower_reg;
			w_upper = upper_reg;
			w_jump  = jump_reg;
			seen    = 0;
			foreach (tried[i]) tried[i] = 0;
		endfunction

		function void write_reg(logic [2:0] idx, logic [31:0] value);
			case (idx)
			REG_STRATEGY:    strategy   = value[2:0];
			REG_LOWER_BOUND: lower_reg  = int'(value[LSC_LAT_BITS-1:0]);
			REG_UPPER_BOUND: upper_reg  = int'(value[LSC_LAT_BITS-1:0]);
			REG_JUMP_LENGTH: jump_reg   = value[LSC_LAT_BITS] ? -1 :
				int'(value[LSC_LAT_BITS-1:0]);
			REG_SINGLE_TRY:  single_try = value[0];
			default: ;
			endcase
		endfunction

		// Returns 1 when the latency had not been tried yet.
		function bit mark_tried(int c);
			int idx;
			idx = c & LAT_MAX;
			if (tried[idx])
				return 0;
			tried[idx] = 1;
			return 1;
		endfunction

		function int jump_up();
			int c;
			c = cand + w_jump;
			return (c > w_upper) ? w_upper : c;
		endfunction

		// Works out the result of one accepted request.
		function void note_request(bit cmd, bit ok);
			int c, range_w;
			bit go;
			c  = cand;
			go = 0;
			if (cmd == CMD_RESTART) begin
				restart_search();
				last_go = 0;
				expected_q.push_back('{cand: '1, go: 1'b0});
				return;
			end
			if (ok && c >= 0)
				seen = 1;
			if (w_jump < 0) begin
				range_w = (w_upper > w_lower) ? w_upper - w_lower : 0;
				w_jump = 0;
				while (4 * w_jump * w_jump < range_w)
					w_jump++;
			end
			if (single_try || strategy == STRAT_NONE) begin
				if (c < 0) begin
					cand = w_upper;
					go = 1;
				end
			end else begin
				case (strategy)
				STRAT_REV_LINEAR: begin
					if (c < 0) begin
						cand = w_upper;
						go = 1;
					end else if (ok && c > w_lower) begin
						cand = c - 1;
						go = 1;
					end
				end
				STRAT_LINEAR: begin
					if (c < 0) begin
						cand = w_lower;
						go = 1;
					end else if (!ok && c < w_upper) begin
						cand = c + 1;
						go = 1;
					end
				end
				STRAT_LINEAR_JUMP: begin
					if (c < 0) begin
						cand = w_lower + w_jump;
						if (cand > w_upper)
							cand = w_upper;
						go = 1;
					end else if (ok) begin
						if (c > w_lower) begin
							w_upper = c;
							cand = c - 1;
							go = 1;
						end
					end else if (!seen && c < w_upper) begin
						w_lower = c + 1;
						cand = jump_up();
						go = 1;
					end
				end
				STRAT_JUMP_BINARY: begin
					if (c < 0) begin
						cand = w_lower;
						go = 1;
					end else if (seen) begin
						if (ok) begin
							w_upper = c;
							cand = (c + w_lower) >> 1;
						end else begin
							// The lower bound saturates at the greatest latency.
							w_lower = (c < LAT_MAX) ? c + 1 : LAT_MAX;
							cand = (c + w_upper + 1) >> 1;
						end
						go = mark_tried(cand);
					end else if (c < w_upper) begin
						w_lower = c + 1;
						cand = jump_up();
						go = 1;
					end
				end
				STRAT_BINARY: begin
					if (c < 0) begin
						cand = w_lower;
					end else if (ok) begin
						w_upper = c;
						cand = (c + w_lower) >> 1;
					end else begin
						w_lower = c;
						cand = (c + w_upper + 1) >> 1;
					end
					go = mark_tried(cand);
				end
				default: ;
				endcase
			end
			last_go = go;
			expected_q.push_back('{cand: cand[LSC_LAT_BITS:0], go: go});
		endfunction

		function int pending();
			return expected_q.size();
		endfunction

		function void check_result(logic [RES_BITS-1:0] data);
			lat_result_t exp_r;
			if (expected_q.size() == 0) begin
				if (errors < 50)
					$display("%0t: unexpected result, candidate_latency %0d keep_going %0b",
						$time, $signed(data[LSC_LAT_BITS:0]), data[LSC_LAT_BITS+1]);
				errors++;
				return;
			end
			exp_r = expected_q.pop_front();
			if (data[LSC_LAT_BITS:0] !== exp_r.cand) begin
				if (errors < 50)
					$display("%0t: candidate_latency expected %0d got %0d", $time,
						$signed(exp_r.cand), $signed(data[LSC_LAT_BITS:0]));
				errors++;
			end
			if (data[LSC_LAT_BITS+1] !== exp_r.go) begin
				if (errors < 50)
					$display("%0t: keep_going expected %0b got %0b", $time,
						exp_r.go, data[LSC_LAT_BITS+1]);
				errors++;
			end
			if (data[RES_BITS-1:LSC_LAT_BITS+2] !== '0) begin
				if (errors < 50)
					$display("%0t: m_tdata padding expected 0 got %0h", $time,
						data[RES_BITS-1:LSC_LAT_BITS+2]);
				errors++;
			end
		endfunction
	endclass

	logic                     clk;
	logic                     arst_n;
	logic                     s_tvalid;
	logic                     s_tready;
	logic [LSC_IN_BITS-1:0]   s_tdata;   // [0] attempt_success, rest zero
	logic                     s_tuser;   // [0] command
	logic                     m_tvalid;
	logic                     m_tready = 1'b0;
	logic [RES_BITS-1:0]      m_tdata;   // [10:0] candidate_latency, [11] keep_going, zeros
	logic                     psel;
	logic                     penable;
	logic                     pwrite;
	logic [LSC_ADDR_BITS-1:0] paddr;
	logic [LSC_DATA_BITS-1:0] pwdata;
	logic [LSC_DATA_BITS-1:0] prdata;
	logic                     pready;

	latency_scoreboard sb;
	int send_idle_pct;
	int recv_stall_pct;
	int cycle_count;
	int cfg_lo, cfg_hi;

	latency_search_controller u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Run time guard.
	initial cycle_count = 0;
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_CAP) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	// Result side: random back-pressure, checking on each accepted result.
	always @(negedge clk) begin
		m_tready <= ($urandom_range(99) >= recv_stall_pct);
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			sb.check_result(m_tdata);
	end

	// Sends one request and notes it at the edge where it is accepted.
	task automatic push_request(input bit cmd, input bit ok);
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid = 1'b0;
			@(negedge clk);
		end
		s_tvalid = 1'b1;
		s_tuser  = cmd;
		s_tdata  = {{(LSC_IN_BITS-1){1'b0}}, ok};
		do
			@(posedge clk);
		while (!s_tready);
		sb.note_request(cmd, ok);
	endtask

	// Waits until every result is back and the block takes requests again.
	task automatic wait_quiet();
		@(negedge clk);
		s_tvalid = 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		while (!s_tready)
			@(posedge clk);
	endtask

	task automatic apb_write(input logic [2:0] idx, input logic [31:0] value);
		@(negedge clk);
		psel    = 1'b1;
		penable = 1'b0;
		pwrite  = 1'b1;
		paddr   = {idx, 2'b00};
		pwdata  = value;
		@(negedge clk);
		penable = 1'b1;
		do
			@(posedge clk);
		while (!pready);
		sb.write_reg(idx, value);
		@(negedge clk);
		psel    = 1'b0;
		penable = 1'b0;
		pwrite  = 1'b0;
	endtask

	task automatic program_search(input logic [2:0] strat, input int lo, input int hi,
		input logic [LSC_LAT_BITS:0] jump, input bit single);
		wait_quiet();
		apb_write(REG_STRATEGY, 32'(strat));
		apb_write(REG_LOWER_BOUND, 32'(lo));
		apb_write(REG_UPPER_BOUND, 32'(hi));
		apb_write(REG_JUMP_LENGTH, 32'(jump));
		apb_write(REG_SINGLE_TRY, 32'(single));
		cfg_lo = lo;
		cfg_hi = hi;
	endtask

	// Picks one register setting; a few phases pin the extremes.
	task automatic random_config(input int phase);
		logic [2:0] strat;
		logic [LSC_LAT_BITS:0] jump;
		int lo, hi, r;
		bit single;
		r = $urandom_range(99);
		strat = (r < 92) ? 3'($urandom_range(5)) : ((r < 96) ? STRAT_RSVD_6 : STRAT_RSVD_7);
		single = ($urandom_range(99) < 12);
		r = $urandom_range(99);
		if (r < 60) begin
			lo = $urandom_range(LAT_MAX);
			hi = lo + $urandom_range(40);
			if (hi > LAT_MAX)
				hi = LAT_MAX;
		end else if (r < 70) begin
			hi = $urandom_range(LAT_MAX - 30);
			lo = hi + $urandom_range(30, 1);
		end else if (r < 80) begin
			lo = 0;
			hi = LAT_MAX;
		end else if (r < 90) begin
			lo = LAT_MAX - $urandom_range(20);
			hi = LAT_MAX;
		end else begin
			lo = $urandom_range(LAT_MAX);
			hi = $urandom_range(LAT_MAX);
		end
		r = $urandom_range(99);
		if (r < 40)
			jump = {1'b1, LSC_LAT_BITS'($urandom)};
		else if (r < 75)
			jump = (LSC_LAT_BITS + 1)'($urandom_range(8));
		else
			jump = (LSC_LAT_BITS + 1)'($urandom_range(LAT_MAX));
		if (phase == 2) begin
			lo = 0;
			hi = LAT_MAX;
			jump = (LSC_LAT_BITS + 1)'(LAT_MAX);
		end else if (phase == 5) begin
			strat = STRAT_LINEAR_JUMP;
			jump = '0;
			single = 0;
		end
		program_search(strat, lo, hi, jump, single);
	endtask

	// One search: usually a restart, then reports whose outcome follows a hidden
	// feasibility threshold, with some noise and the odd restart midway.
	task automatic run_search(inout int items);
		int thr, steps, extra;
		bit ok;
		if ($urandom_range(9) != 0) begin
			push_request(CMD_RESTART, 1'($urandom));
			items++;
		end
		if (cfg_hi >= cfg_lo)
			thr = $urandom_range(cfg_hi + 1, cfg_lo);
		else
			thr = $urandom_range(LAT_MAX + 1);
		steps = 0;
		extra = $urandom_range(3);
		while (steps < SEARCH_CAP) begin
			if ($urandom_range(99) < 2) begin
				push_request(CMD_RESTART, 1'($urandom));
				items++;
				break;
			end
			if ($urandom_range(99) < 8 || sb.cand < 0)
				ok = 1'($urandom);
			else
				ok = (sb.cand >= thr);
			push_request(CMD_REPORT, ok);
			items++;
			steps++;
			if (!sb.last_go) begin
				if (extra == 0)
					break;
				extra--;
			end
		end
	endtask

	// Main sequence.
	initial begin
		int items;
		sb = new();
		sb.power_on();
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		arst_n   = 1'b0;
		s_tvalid = 1'b0;
		s_tuser  = CMD_REPORT;
		s_tdata  = '0;
		psel     = 1'b0;
		penable  = 1'b0;
		pwrite   = 1'b0;
		paddr    = '0;
		pwdata   = '0;
		cfg_lo   = 0;
		cfg_hi   = 0;
		repeat (11) @(negedge clk);
		arst_n = 1'b1;

		// Reset settings: a success with no candidate yet is ignored, then the
		// reverse search stops at the lower bound and repeats its decision.
		wait_quiet();
		push_request(CMD_REPORT, 1'b1);
		push_request(CMD_REPORT, 1'b1);
		push_request(CMD_REPORT, 1'b0);

		// Bisect at the greatest latency: the lower bound saturates.
		program_search(STRAT_JUMP_BINARY, LAT_MAX, LAT_MAX, 11'd1, 1'b0);
		push_request(CMD_RESTART, 1'b0);
		push_request(CMD_REPORT, 1'b0);
		push_request(CMD_REPORT, 1'b1);
		push_request(CMD_REPORT, 1'b0);

		// Automatic jump with the upper bound below the lower bound.
		program_search(STRAT_LINEAR_JUMP, 500, 400, 11'h400, 1'b0);
		push_request(CMD_RESTART, 1'b1);
		push_request(CMD_REPORT, 1'b0);
		push_request(CMD_REPORT, 1'b0);
		push_request(CMD_REPORT, 1'b1);

		// Full range binary search with automatic jump.
		program_search(STRAT_BINARY, 0, LAT_MAX, 11'h7FF, 1'b0);
		push_request(CMD_RESTART, 1'b0);
		push_request(CMD_REPORT, 1'b0);
		push_request(CMD_REPORT, 1'b0);
		push_request(CMD_REPORT, 1'b0);
		push_request(CMD_REPORT, 1'b1);

		// Undefined strategy codes leave the state alone.
		program_search(STRAT_RSVD_7, 0, LAT_MAX, 11'd1023, 1'b0);
		push_request(CMD_REPORT, 1'b1);
		program_search(STRAT_RSVD_6, 0, LAT_MAX, 11'd1023, 1'b0);
		push_request(CMD_REPORT, 1'b0);

		// Single try overrides the linear strategy.
		program_search(STRAT_LINEAR, 3, 9, 11'd2, 1'b1);
		push_request(CMD_RESTART, 1'b0);
		push_request(CMD_REPORT, 1'b0);
		push_request(CMD_REPORT, 1'b0);

		// Linear search runs up to the upper bound.
		program_search(STRAT_LINEAR, 0, 1, 11'd0, 1'b0);
		push_request(CMD_RESTART, 1'b0);
		push_request(CMD_REPORT, 1'b0);
		push_request(CMD_REPORT, 1'b0);
		push_request(CMD_REPORT, 1'b0);

		// Random phases, cycling through the idle and stall mixes.
		for (int phase = 0; phase < NUM_PHASES; phase++) begin
			wait_quiet();
			case (phase % 4)
			0: begin
				send_idle_pct  = 0;
				recv_stall_pct = 0;
			end
			1: begin
				send_idle_pct  = 47;
				recv_stall_pct = 0;
			end
			2: begin
				send_idle_pct  = 0;
				recv_stall_pct = 47;
			end
			default: begin
				send_idle_pct  = 17;
				recv_stall_pct = 17;
			end
			endcase
			random_config(phase);
			items = 0;
			while (items < PHASE_ITEMS)
				run_search(items);
		end

		// Drain and let any stray result show up.
		@(negedge clk);
		s_tvalid = 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);
		if (sb.errors == 0 && sb.pending() == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
